@@ design/pcbd_pkg.sv @@
// package: constants, tables, types and helpers shared by the block dither design
`default_nettype none

package pcbd_pkg;

  localparam int LINE_WIDTH     = 320;
  localparam int BLOCK_PIXELS   = 8;
  localparam int PALETTE_COLORS = 16;

  localparam int COL_W   = $clog2(LINE_WIDTH);
  localparam int K_W     = $clog2(BLOCK_PIXELS);
  localparam int CNT_W   = $clog2(BLOCK_PIXELS + 1);
  localparam int PAL_W   = 4;
  localparam int PCNT_W  = $clog2(PALETTE_COLORS + 1);
  localparam int HALF_N  = (BLOCK_PIXELS + 1) / 2;
  localparam int QUEUE_DEPTH = 2;

  localparam int Q_W     = 12;
  localparam int PRE_W   = 14;
  localparam int ERR_W   = 14;
  localparam int AMP_W   = 12;
  localparam int GAIN_W  = 8;
  localparam int BIAS_Y_W = 18;
  localparam int CURVE_W = 19;
  localparam int DIST_W  = 34;
  localparam int COST_W  = DIST_W + $clog2(BLOCK_PIXELS);
  localparam int ERR_ROW_W = 3 * ERR_W;

  localparam logic [Q_W-1:0]  FULL_Q   = 12'd4095;
  localparam logic [Q_W-1:0]  LOW_Q    = 12'd3324;
  localparam logic [11:0]     W_RB     = 12'd2702;
  localparam logic [12:0]     W_G      = 13'd4794;
  localparam logic [12:0]     RECIP63  = 13'd4161;
  localparam logic [7:0]      LVL_FULL = 8'd255;
  localparam logic [7:0]      LVL_LOW  = 8'd207;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_BAYER_AMP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_GAIN  = 1'b1;
  localparam logic [AMP_W-1:0]     AMP_RESET      = 12'd385;
  localparam logic [GAIN_W-1:0]    GAIN_RESET     = 8'd154;

  typedef logic [PRE_W-1:0]           pre_t;
  typedef pre_t [2:0]                 pre_rgb_t;
  typedef logic [DIST_W-1:0]          dist_t;
  typedef dist_t [BLOCK_PIXELS-1:0]   dist_row_t;

  typedef struct packed {
    pre_rgb_t [BLOCK_PIXELS-1:0] pre;
    logic [CNT_W-1:0]            count;
    logic [COL_W-1:0]            base;
    logic                        first;
  } blk_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LOAD,
    BK_DIST,
    BK_ROW,
    BK_ROWCAP,
    BK_PAIRS,
    BK_DRAIN,
    BK_PICK0,
    BK_PICK1,
    BK_PICK2,
    BK_EMIT
  } bk_state_t;

  typedef logic [Q_W-1:0]     q_tab_t [256];
  typedef logic [CURVE_W-1:0] curve_tab_t [65];

  // 8 bit level to q0.12, rounded
  function automatic q_tab_t build_q_tab();
    q_tab_t t;
    for (int x = 0; x < 256; x++) begin
      t[x] = Q_W'((x * 4095 + 127) / 255);
    end
    return t;
  endfunction

  // i * floor(fifth root of 2^36 * i^4)
  function automatic curve_tab_t build_curve_tab();
    curve_tab_t t;
    logic [63:0] n;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    for (int i = 0; i <= 64; i++) begin
      n  = (64'(i) * 64'(i) * 64'(i) * 64'(i)) << 36;
      lo = 64'd0;
      hi = 64'd4096;
      for (int s = 0; s < 20; s++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          p   = mid * mid * mid * mid * mid;
          if (p <= n) lo = mid;
          else hi = mid - 64'd1;
        end
      end
      t[i] = CURVE_W'(64'(i) * lo);
    end
    return t;
  endfunction

  localparam q_tab_t     Q8_TO_Q12 = build_q_tab();
  localparam curve_tab_t CURVE_LUT = build_curve_tab();

  function automatic logic [Q_W-1:0] pal_q(input logic [PAL_W-1:0] c, input int ch);
    if (!c[ch]) return '0;
    return c[3] ? FULL_Q : LOW_Q;
  endfunction

  function automatic logic [7:0] pal_level(input logic [PAL_W-1:0] c, input int ch);
    if (!c[ch]) return '0;
    return c[3] ? LVL_FULL : LVL_LOW;
  endfunction

endpackage

`default_nettype wire

@@ design/pcbd_if.sv @@
// pixel and result channel interfaces
`default_nettype none

interface pcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       frame_start;
  modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface pcbd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] color_index;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       last_of_block;
  modport source (output valid, color_index, red_out, green_out, blue_out, last_of_block,
                  input ready);
  modport sink   (input valid, color_index, red_out, green_out, blue_out, last_of_block,
                  output ready);
endinterface

`default_nettype wire

@@ design/pcbd_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module pcbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/pcbd_front.sv @@
// front end: pixel position, bayer bias, block gathering
`default_nettype none

module pcbd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  pcbd_in_if.sink                     in_if,
  input  logic [pcbd_pkg::AMP_W-1:0]  amp,
  output logic                        push_valid,
  input  logic                        push_ready,
  output pcbd_pkg::blk_t              push_data
);
  import pcbd_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [2:0]       row_r, row_nxt;
  logic             first_r, first_nxt;
  logic             s1_v_r, s1_v_nxt;

  logic [Q_W-1:0]      s1_q_r [3];
  logic [BIAS_Y_W-1:0] s1_y_r;
  logic                s1_neg_r;
  logic [K_W-1:0]      s1_k_r;
  logic                s1_close_r;
  logic [COL_W-1:0]    s1_base_r;
  logic                s1_first_r;
  pre_rgb_t            buf_r [BLOCK_PIXELS];

  logic             accept;
  logic [COL_W-1:0] col;
  logic [K_W-1:0]   k;
  logic [2:0]       row;
  logic             first;
  logic [5:0]       rank;
  logic [5:0]       m;
  logic             close;
  logic [30:0]      prod;
  logic [Q_W-1:0]   mag;
  pre_rgb_t         pre_now;

  assign in_if.ready = !s1_v_r;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    col   = in_if.frame_start ? '0 : col_r;
    k     = in_if.frame_start ? '0 : k_r;
    row   = in_if.frame_start ? '0 : row_r;
    first = in_if.frame_start ? 1'b1 : first_r;
    rank  = {row[2], col[2], row[1], col[1], row[0], col[0]};
    m     = rank[5] ? {rank[4:0], 1'b1} : {~rank[4:0], 1'b1};
    close = (k == K_W'(BLOCK_PIXELS - 1)) || (col == COL_W'(LINE_WIDTH - 1));

    col_nxt   = col_r;
    k_nxt     = k_r;
    row_nxt   = row_r;
    first_nxt = first_r;
    if (accept) begin
      k_nxt = close ? '0 : k + K_W'(1);
      if (col == COL_W'(LINE_WIDTH - 1)) begin
        col_nxt   = '0;
        row_nxt   = row + 3'd1;
        first_nxt = 1'b0;
      end else begin
        col_nxt   = col + COL_W'(1);
        row_nxt   = row;
        first_nxt = first;
      end
    end
  end

  // bias magnitude = y * 4161 >> 18, close to floor(y / 63), y already carries the +32
  always_comb begin
    prod = 31'(s1_y_r) * 31'(RECIP63);
    mag  = prod[29:18];
    for (int ch = 0; ch < 3; ch++) begin
      pre_now[ch] = s1_neg_r ? PRE_W'({2'b00, s1_q_r[ch]}) - PRE_W'({2'b00, mag})
                             : PRE_W'({2'b00, s1_q_r[ch]}) + PRE_W'({2'b00, mag});
    end
  end

  assign push_valid = s1_v_r && s1_close_r;

  always_comb begin
    for (int p = 0; p < BLOCK_PIXELS; p++) begin
      push_data.pre[p] = (K_W'(p) == s1_k_r) ? pre_now : buf_r[p];
    end
    push_data.count = CNT_W'(s1_k_r) + CNT_W'(1);
    push_data.base  = s1_base_r;
    push_data.first = s1_first_r;
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_v_r && (!s1_close_r || push_ready)) s1_v_nxt = 1'b0;
    if (accept) s1_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      k_r     <= '0;
      row_r   <= '0;
      first_r <= 1'b1;
      s1_v_r  <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      k_r     <= k_nxt;
      row_r   <= row_nxt;
      first_r <= first_nxt;
      s1_v_r  <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_q_r[0]  <= Q8_TO_Q12[in_if.red_in];
      s1_q_r[1]  <= Q8_TO_Q12[in_if.green_in];
      s1_q_r[2]  <= Q8_TO_Q12[in_if.blue_in];
      s1_y_r     <= BIAS_Y_W'(amp) * BIAS_Y_W'(m) + BIAS_Y_W'(32);
      s1_neg_r   <= !rank[5];
      s1_k_r     <= k;
      s1_close_r <= close;
      s1_base_r  <= col - COL_W'(k);
      s1_first_r <= first;
    end
    if (s1_v_r) begin
      buf_r[s1_k_r] <= pre_now;
    end
  end

endmodule

`default_nettype wire

@@ design/pcbd_queue.sv @@
// two entry block queue between front and back
`default_nettype none

module pcbd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  pcbd_pkg::blk_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output pcbd_pkg::blk_t head
);
  import pcbd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  blk_t              ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wp_r, rp_r;
  logic [FILL_W-1:0] fill_r;
  logic              do_push, do_pop;

  assign push_ready = fill_r != FILL_W'(QUEUE_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign head       = ent_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
      if (do_pop)  rp_r <= (rp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
      fill_r <= fill_r + FILL_W'(do_push) - FILL_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_data;
  end

endmodule

`default_nettype wire

@@ design/pcbd_back.sv @@
// back end: error add, distance table, pair search, result emit, error store
`default_nettype none

module pcbd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  pcbd_pkg::blk_t              q_head,
  input  logic [pcbd_pkg::GAIN_W-1:0] gain,
  pcbd_out_if.source                  out_if
);
  import pcbd_pkg::*;

  localparam logic [PAL_W-1:0] LAST_C = PAL_W'(PALETTE_COLORS - 1);

  bk_state_t st_r, st_nxt;

  logic [CNT_W-1:0] p_r;
  logic             ld_v_r;
  logic [K_W-1:0]   ld_t_r;
  logic [Q_W-1:0]   pix_r [BLOCK_PIXELS][3];

  // distance table pipeline
  logic [PCNT_W-1:0]  c_r;
  logic               va_r, vb_r;
  logic [PAL_W-1:0]   ta_r, tb_r;
  logic [CURVE_W-1:0] ca_r [BLOCK_PIXELS][3];
  logic [CURVE_W-1:0] da_r [BLOCK_PIXELS][3];
  logic [5:0]         fa_r [BLOCK_PIXELS][3];
  logic [CURVE_W-1:0] cb_r [BLOCK_PIXELS][3];

  // pair search pipeline
  logic [PAL_W-1:0]        i_r, j_r;
  logic                    iss_v_r, v1_r, v2_r, v3_r;
  logic [PAL_W-1:0]        iss_i_r, iss_j_r, i1_r, j1_r, i2_r, j2_r, i3_r, j3_r;
  dist_row_t               di_r;
  logic [DIST_W-1:0]       min_r [BLOCK_PIXELS];
  logic [DIST_W:0]         half_r [HALF_N];
  logic [COST_W-1:0]       cost_r;
  logic                    have_r;
  logic [COST_W-1:0]       best_r;
  logic [PAL_W-1:0]        bi_r, bj_r;
  logic [PAL_W-1:0]        pick_r [BLOCK_PIXELS];

  logic       out_v_r;
  logic [3:0] out_ci_r;
  logic [7:0] out_r_r, out_g_r, out_b_r;
  logic       out_last_r;

  // rams
  logic                      d_we;
  logic [PAL_W-1:0]          d_raddr;
  dist_row_t                 d_wdata, d_rdata;
  logic                      e_we;
  logic [COL_W-1:0]          e_addr;
  logic [ERR_ROW_W-1:0]      e_wdata, e_rdata;

  logic             emit_go, emit_last;
  logic             ld_issue, c_issue, pair_issue, dist_done, pipe_empty;
  logic [K_W-1:0]   sel;
  logic [PAL_W-1:0] emit_c;

  logic [CURVE_W-1:0] ca_nxt [BLOCK_PIXELS][3];
  logic [CURVE_W-1:0] da_nxt [BLOCK_PIXELS][3];
  logic [5:0]         fa_nxt [BLOCK_PIXELS][3];
  logic [CURVE_W-1:0] cb_nxt [BLOCK_PIXELS][3];
  logic [Q_W-1:0]     pix_nxt [3];
  logic [DIST_W-1:0]  min_nxt [BLOCK_PIXELS];
  logic [DIST_W:0]    half_nxt [HALF_N];
  logic [COST_W-1:0]  cost_nxt;

  pcbd_ram #(.WIDTH(BLOCK_PIXELS * DIST_W), .DEPTH(PALETTE_COLORS)) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (tb_r),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  pcbd_ram #(.WIDTH(ERR_ROW_W), .DEPTH(LINE_WIDTH)) u_err_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_addr),
    .wdata (e_wdata),
    .raddr (e_addr),
    .rdata (e_rdata)
  );

  assign emit_go    = !out_v_r || out_if.ready;
  assign emit_last  = p_r == q_head.count - CNT_W'(1);
  assign ld_issue   = (st_r == BK_LOAD) && (p_r < q_head.count);
  assign c_issue    = (st_r == BK_DIST) && (c_r < PCNT_W'(PALETTE_COLORS));
  assign dist_done  = (c_r == PCNT_W'(PALETTE_COLORS)) && !va_r && !vb_r;
  assign pair_issue = (st_r == BK_ROWCAP) || (st_r == BK_PAIRS);
  assign pipe_empty = !iss_v_r && !v1_r && !v2_r && !v3_r;
  assign sel        = p_r[K_W-1:0];
  assign emit_c     = pick_r[sel];
  assign e_addr     = q_head.base + COL_W'(p_r);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE:   if (q_valid) st_nxt = BK_LOAD;
      BK_LOAD:   if (p_r == q_head.count && !ld_v_r) st_nxt = BK_DIST;
      BK_DIST:   if (dist_done) st_nxt = BK_ROW;
      BK_ROW:    st_nxt = BK_ROWCAP;
      BK_ROWCAP,
      BK_PAIRS: begin
        if (j_r == LAST_C) st_nxt = (i_r == LAST_C - PAL_W'(1)) ? BK_DRAIN : BK_ROW;
        else st_nxt = BK_PAIRS;
      end
      BK_DRAIN:  if (pipe_empty) st_nxt = BK_PICK0;
      BK_PICK0:  st_nxt = BK_PICK1;
      BK_PICK1:  st_nxt = BK_PICK2;
      BK_PICK2:  st_nxt = BK_EMIT;
      BK_EMIT:   if (emit_go && emit_last) st_nxt = BK_IDLE;
      default:   st_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    d_raddr = j_r;
    q_pop   = 1'b0;
    e_we    = 1'b0;
    unique case (st_r)
      BK_ROW:   d_raddr = i_r;
      BK_PICK0: d_raddr = bi_r;
      BK_PICK1: d_raddr = bj_r;
      BK_EMIT: begin
        e_we  = emit_go;
        q_pop = emit_go && emit_last;
      end
      default: d_raddr = j_r;
    endcase
  end

  // error for the next line, scaled by the gain and rounded to nearest, halves away from zero
  always_comb begin
    logic signed [Q_W:0] e;
    logic [Q_W-1:0]      em;
    logic [20:0]         sp;
    logic [Q_W-1:0]      s;
    e_wdata = '0;
    for (int ch = 0; ch < 3; ch++) begin
      e  = $signed({1'b0, pix_r[sel][ch]}) - $signed({1'b0, pal_q(emit_c, ch)});
      em = e[Q_W] ? Q_W'(-e) : e[Q_W-1:0];
      sp = 21'(em) * 21'(gain) + 21'd128;
      s  = sp[19:8];
      e_wdata[ch*ERR_W +: ERR_W] = e[Q_W] ? -ERR_W'(s) : ERR_W'(s);
    end
  end

  // stored error added to the biased pixel, clamped
  always_comb begin
    logic signed [PRE_W:0] v;
    logic signed [ERR_W-1:0] er;
    for (int ch = 0; ch < 3; ch++) begin
      er = q_head.first ? '0 : $signed(e_rdata[ch*ERR_W +: ERR_W]);
      v  = $signed({q_head.pre[ld_t_r][ch][PRE_W-1], q_head.pre[ld_t_r][ch]})
           + $signed({er[ERR_W-1], er});
      if (v < 0) pix_nxt[ch] = '0;
      else if (v > $signed({3'b000, FULL_Q})) pix_nxt[ch] = FULL_Q;
      else pix_nxt[ch] = v[Q_W-1:0];
    end
  end

  // curve lookup and interpolation, one colour for all block pixels
  always_comb begin
    logic [Q_W-1:0]     pq, d;
    logic [CURVE_W-1:0] a, b;
    logic [25:0]        ip;
    for (int p = 0; p < BLOCK_PIXELS; p++) begin
      for (int ch = 0; ch < 3; ch++) begin
        pq = pal_q(c_r[PAL_W-1:0], ch);
        d  = (pix_r[p][ch] > pq) ? pix_r[p][ch] - pq : pq - pix_r[p][ch];
        a  = CURVE_LUT[d[11:6]];
        b  = CURVE_LUT[7'(d[11:6]) + 7'd1];
        ca_nxt[p][ch] = a;
        da_nxt[p][ch] = b - a;
        fa_nxt[p][ch] = d[5:0];
        ip = 26'(da_r[p][ch]) * 26'(fa_r[p][ch]) + 26'd32;
        cb_nxt[p][ch] = ca_r[p][ch] + CURVE_W'(ip[25:6]);
      end
    end
  end

  always_comb begin
    for (int p = 0; p < BLOCK_PIXELS; p++) begin
      d_wdata[p] = DIST_W'(W_RB) * (DIST_W'(cb_r[p][0]) + DIST_W'(cb_r[p][2]))
                   + DIST_W'(W_G) * DIST_W'(cb_r[p][1]);
    end
  end
  assign d_we = vb_r;

  // cost of one pair: per pixel minimum, then a two level sum
  always_comb begin
    for (int p = 0; p < BLOCK_PIXELS; p++) begin
      if (CNT_W'(p) < q_head.count)
        min_nxt[p] = (di_r[p] < d_rdata[p]) ? di_r[p] : d_rdata[p];
      else
        min_nxt[p] = '0;
    end
    for (int h = 0; h < HALF_N; h++) begin
      if (2 * h + 1 < BLOCK_PIXELS)
        half_nxt[h] = {1'b0, min_r[2*h]} + {1'b0, min_r[2*h+1]};
      else
        half_nxt[h] = {1'b0, min_r[2*h]};
    end
    cost_nxt = '0;
    for (int h = 0; h < HALF_N; h++) begin
      cost_nxt = cost_nxt + COST_W'(half_r[h]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      p_r     <= '0;
      ld_v_r  <= 1'b0;
      c_r     <= '0;
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      iss_v_r <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      have_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      ld_v_r  <= ld_issue;
      va_r    <= c_issue;
      vb_r    <= va_r;
      iss_v_r <= pair_issue;
      v1_r    <= iss_v_r;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      if (out_v_r && out_if.ready && !(st_r == BK_EMIT && emit_go)) out_v_r <= 1'b0;
      if (v3_r && (!have_r || cost_r < best_r)) have_r <= 1'b1;
      case (st_r)
        BK_IDLE: begin
          p_r    <= '0;
          c_r    <= '0;
          have_r <= 1'b0;
        end
        BK_LOAD: if (ld_issue) p_r <= p_r + CNT_W'(1);
        BK_DIST: begin
          if (c_issue) c_r <= c_r + PCNT_W'(1);
          i_r <= '0;
        end
        BK_ROW:  j_r <= i_r + PAL_W'(1);
        BK_ROWCAP, BK_PAIRS: begin
          j_r <= j_r + PAL_W'(1);
          if (j_r == LAST_C) i_r <= i_r + PAL_W'(1);
        end
        BK_PICK2: p_r <= '0;
        BK_EMIT: begin
          if (emit_go) begin
            p_r     <= p_r + CNT_W'(1);
            out_v_r <= 1'b1;
          end
        end
        default: p_r <= p_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ld_v_r) begin
      for (int ch = 0; ch < 3; ch++) pix_r[ld_t_r][ch] <= pix_nxt[ch];
    end
    ld_t_r <= p_r[K_W-1:0];
    ta_r   <= c_r[PAL_W-1:0];
    tb_r   <= ta_r;
    ca_r   <= ca_nxt;
    da_r   <= da_nxt;
    fa_r   <= fa_nxt;
    cb_r   <= cb_nxt;
    iss_i_r <= i_r;
    iss_j_r <= j_r;
    i1_r   <= iss_i_r;
    j1_r   <= iss_j_r;
    i2_r   <= i1_r;
    j2_r   <= j1_r;
    i3_r   <= i2_r;
    j3_r   <= j2_r;
    min_r  <= min_nxt;
    half_r <= half_nxt;
    cost_r <= cost_nxt;
    if (st_r == BK_ROWCAP || st_r == BK_PICK1) di_r <= d_rdata;
    if (v3_r && (!have_r || cost_r < best_r)) begin
      best_r <= cost_r;
      bi_r   <= i3_r;
      bj_r   <= j3_r;
    end
    if (st_r == BK_PICK2) begin
      // equal distance goes to the second colour
      for (int p = 0; p < BLOCK_PIXELS; p++) begin
        pick_r[p] <= (di_r[p] < d_rdata[p]) ? bi_r : bj_r;
      end
    end
    if (st_r == BK_EMIT && emit_go) begin
      out_ci_r   <= emit_c;
      out_r_r    <= pal_level(emit_c, 0);
      out_g_r    <= pal_level(emit_c, 1);
      out_b_r    <= pal_level(emit_c, 2);
      out_last_r <= emit_last;
    end
  end

  assign out_if.valid         = out_v_r;
  assign out_if.color_index   = out_ci_r;
  assign out_if.red_out       = out_r_r;
  assign out_if.green_out     = out_g_r;
  assign out_if.blue_out      = out_b_r;
  assign out_if.last_of_block = out_last_r;

endmodule

`default_nettype wire

@@ design/pair_constrained_block_dither_top.sv @@
// Block ordered dither to a 16 colour rgbi palette with one colour pair per block.
// Pixels enter on in_if into the front end, which takes a new pixel only while its
// register stage is empty, adds the bayer bias and gathers a block; full blocks wait
// in a two block queue. The back end adds the stored column error, builds a 16 row
// distance table, then sweeps all colour pairs reading one table row per cycle, and
// emits the block's items on out_if. The back end takes a new block only after the
// last item of the current one, and the pair sweep takes most of its time per block.
// Configuration writes are taken at any cycle with cfg_we high.
`default_nettype none

module pair_constrained_block_dither_top (
  input  logic                              clk,
  input  logic                              rst_n,
  pcbd_in_if.sink                           in_if,
  pcbd_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [pcbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcbd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pcbd_pkg::*;

  logic [AMP_W-1:0]  amp_r;
  logic [GAIN_W-1:0] gain_r;
  logic              push_valid, push_ready, q_valid, q_pop;
  blk_t              push_data, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r  <= AMP_RESET;
      gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BAYER_AMP: amp_r  <= cfg_data[AMP_W-1:0];
        CFG_DIFF_GAIN: gain_r <= cfg_data[GAIN_W-1:0];
        default:       amp_r  <= amp_r;
      endcase
    end
  end

  pcbd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .amp        (amp_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pcbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .head       (q_head)
  );

  pcbd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .gain    (gain_r),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire

@@ design/pcbd_checker.sv @@
// port level checks on the result channel, bound to the top level
`default_nettype none

module pcbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] color_index,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out
);

  function automatic logic [7:0] lvl(input logic [3:0] c, input int ch);
    if (!c[ch]) return 8'd0;
    return c[3] ? 8'd255 : 8'd207;
  endfunction

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> red_out == lvl(color_index, 0))
    else $error("red level does not match colour index");

  a_green_blue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (green_out == lvl(color_index, 1)) && (blue_out == lvl(color_index, 2)))
    else $error("green or blue level does not match colour index");

endmodule

bind pair_constrained_block_dither_top pcbd_checker u_pcbd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .color_index (out_if.color_index),
  .red_out     (out_if.red_out),
  .green_out   (out_if.green_out),
  .blue_out    (out_if.blue_out)
);

`default_nettype wire
